// ----- rtl/scvs_pkg.sv -----
// Shared types, codes and defaults for the second-chance victim selector.
package scvs_pkg;

  localparam int NUM_BUFFERS_DEF = 64;
  localparam int NUM_POOLS_DEF   = 2;

  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int FIX_W      = 8;

  localparam logic [CFG_DATA_W-1:0] POOL_SIZE_RST = 7'd64;
  localparam logic [FIX_W-1:0]      FIX_MAX       = 8'd255;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REF   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIX   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UNFIX = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNSUPP  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_FLUSH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_SIZE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             ref_bit;
    logic             dirty_bit;
    logic [FIX_W-1:0] fix_cnt;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             pool;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                flush;
  } res_t;

endpackage

// ----- rtl/scvs_engine.sv -----
// Entry-state memory, per-pool victim pointers and the command/sweep sequencer.
module scvs_engine #(
  parameter int NUM_BUFFERS = scvs_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_POOLS   = scvs_pkg::NUM_POOLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  scvs_pkg::req_t                      req,
  input  logic [$clog2(NUM_BUFFERS)-1:0]      entry_index,
  input  logic                                bulk_flush_enable,
  input  logic [scvs_pkg::CFG_DATA_W-1:0]     page_size,
  input  logic [scvs_pkg::CFG_DATA_W-1:0]     train_size,
  output logic                                idle,
  output logic                                res_valid,
  input  logic                                res_take,
  output scvs_pkg::res_t                      res,
  output logic [$clog2(NUM_BUFFERS)-1:0]      res_victim
);
  import scvs_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam int SZ_W  = IDX_W + 1;
  localparam int CNT_W = IDX_W + 2;
  localparam int DEPTH = NUM_POOLS * NUM_BUFFERS;
  localparam int AW    = $clog2(DEPTH);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [IDX_W-1:0]  vic_r, vic_nxt;
  logic [SZ_W-1:0]   size_r, size_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  res_t              res_r, res_nxt;
  logic [IDX_W-1:0]  resv_r, resv_nxt;
  logic [IDX_W-1:0]  ptr_r [NUM_POOLS];
  logic              ptr_we;
  logic [IDX_W-1:0]  ptr_wdata;

  entry_t            mem [DEPTH];
  entry_t            rdata_r;
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;
  entry_t            wdata;

  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_addr_r;
  entry_t            fwd_data_r;

  entry_t                cur;
  logic [CFG_DATA_W-1:0] raw_size;
  logic [SZ_W-1:0]       eff_size;
  logic [IDX_W-1:0]      ptr_sel, start_idx;
  logic                  bad_cmd, bad_pool, entry_oob;
  logic                  found;
  logic [CNT_W-1:0]      cnt_inc, sweep_lim;
  logic [SZ_W-1:0]       vic_inc;
  logic [IDX_W-1:0]      vic_wrap;

  function automatic logic [AW-1:0] addr_of(input logic pool, input logic [IDX_W-1:0] idx);
    addr_of = AW'(pool) * AW'(NUM_BUFFERS) + AW'(idx);
  endfunction

  // effective pool size: zero acts as one, clamp at NUM_BUFFERS
  always_comb begin
    raw_size = req.pool ? train_size : page_size;
    if (raw_size == '0) begin
      eff_size = SZ_W'(1);
    end else if (32'(raw_size) > 32'(NUM_BUFFERS)) begin
      eff_size = SZ_W'(NUM_BUFFERS);
    end else begin
      eff_size = SZ_W'(raw_size);
    end
  end

  assign ptr_sel   = ptr_r[req.pool];
  assign start_idx = ({1'b0, ptr_sel} >= eff_size) ? '0 : ptr_sel;
  assign bad_cmd   = req.command > CMD_UNFIX;
  assign bad_pool  = 32'(req.pool) >= 32'(NUM_POOLS);
  assign entry_oob = {1'b0, entry_index} >= eff_size;

  // back-to-back sweep steps can hit the entry just written (pool of one)
  assign cur       = (fwd_valid_r && fwd_addr_r == addr_r) ? fwd_data_r : rdata_r;
  assign found     = (cur.fix_cnt == '0) && !cur.ref_bit;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign sweep_lim = {size_r, 1'b0};
  assign vic_inc   = {1'b0, vic_r} + SZ_W'(1);
  assign vic_wrap  = (vic_inc == size_r) ? '0 : vic_inc[IDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (bad_cmd || bad_pool) begin
            state_nxt = ST_DONE;
          end else if (req.command == CMD_ALLOC) begin
            state_nxt = bulk_flush_enable ? ST_DONE : ST_SWEEP;
          end else begin
            state_nxt = entry_oob ? ST_DONE : ST_UPDATE;
          end
        end
      end
      ST_UPDATE: state_nxt = ST_DONE;
      ST_SWEEP: begin
        if (found || cnt_inc == sweep_lim) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt   = req_r;
    vic_nxt   = vic_r;
    size_nxt  = size_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    resv_nxt  = resv_r;
    ptr_we    = 1'b0;
    ptr_wdata = vic_wrap;
    mem_we    = 1'b0;
    waddr     = addr_r;
    wdata     = cur;
    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt  = req;
          size_nxt = eff_size;
          cnt_nxt  = '0;
          vic_nxt  = start_idx;
          res_nxt  = '{status: STATUS_OK, flush: 1'b0};
          resv_nxt = '0;
          if (bad_cmd) begin
            res_nxt.status = STATUS_UNSUPP;
          end else if (bad_pool) begin
            res_nxt.status = STATUS_RANGE;
          end else if (req.command == CMD_ALLOC) begin
            if (bulk_flush_enable) begin
              res_nxt.status = STATUS_UNSUPP;
            end else begin
              addr_nxt = addr_of(req.pool, start_idx);
            end
          end else if (entry_oob) begin
            res_nxt.status = STATUS_RANGE;
          end else begin
            addr_nxt = addr_of(req.pool, entry_index);
          end
        end
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
        case (req_r.command)
          CMD_REF:   wdata.ref_bit   = 1'b1;
          CMD_DIRTY: wdata.dirty_bit = 1'b1;
          CMD_FIX: begin
            if (cur.fix_cnt != FIX_MAX) wdata.fix_cnt = cur.fix_cnt + FIX_W'(1);
          end
          CMD_UNFIX: begin
            if (cur.fix_cnt != '0) wdata.fix_cnt = cur.fix_cnt - FIX_W'(1);
          end
          default: mem_we = 1'b0;
        endcase
      end
      ST_SWEEP: begin
        if (found) begin
          mem_we          = 1'b1;
          wdata.dirty_bit = 1'b0;
          res_nxt.flush   = cur.dirty_bit;
          resv_nxt        = vic_r;
          ptr_we          = 1'b1;
        end else begin
          // unfixed with reference set: second chance, clear it
          mem_we        = (cur.fix_cnt == '0);
          wdata.ref_bit = 1'b0;
          cnt_nxt       = cnt_inc;
          if (cnt_inc == sweep_lim) begin
            res_nxt.status = STATUS_NO_FREE;
          end else begin
            vic_nxt  = vic_wrap;
            addr_nxt = addr_of(req_r.pool, vic_wrap);
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign raddr      = addr_nxt;
  assign idle       = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_DONE);
  assign res        = res_r;
  assign res_victim = resv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      fwd_valid_r <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) ptr_r[p] <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fwd_valid_r <= mem_we;
      if (ptr_we) ptr_r[req_r.pool] <= ptr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    vic_r      <= vic_nxt;
    size_r     <= size_nxt;
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    res_r      <= res_nxt;
    resv_r     <= resv_nxt;
    fwd_addr_r <= waddr;
    fwd_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> cnt_r < sweep_lim)
    else $error("sweep ran past two rounds");

  a_victim_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> {1'b0, vic_r} < size_r)
    else $error("sweep index outside pool");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !mem_we)
    else $error("state memory written outside a command");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && found) |=> (state_r == ST_DONE && res_r.status == STATUS_OK))
    else $error("found victim did not finish the sweep");

endmodule

// ----- rtl/second_chance_victim_select_top.sv -----
// Top level of the second-chance (clock) victim selector for two buffer pools.
// Reference/dirty/fix/unfix pass through the update state, allocate through the sweep
// state (at most 2*pool_size entries examined), rejected commands (unsupported, out of
// range) go straight to done; each result then moves into the output register.
// A new command is taken only once the previous result has left the engine; a stalled
// out_ready holds the engine and in_ready stays low.
// Reset (rst_n low, synchronous): clears every entry, NUM_POOLS*NUM_BUFFERS of them
// (128 by default), with in_ready low; config writes are taken meanwhile.
module second_chance_victim_select_top #(
  parameter int NUM_BUFFERS = scvs_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_POOLS   = scvs_pkg::NUM_POOLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [scvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scvs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // command transaction
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [scvs_pkg::CMD_W-1:0]          in_command,
  input  logic                                in_pool,
  input  logic [$clog2(NUM_BUFFERS)-1:0]      in_entry_index,
  // result transaction
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scvs_pkg::STATUS_W-1:0]       out_status,
  output logic [$clog2(NUM_BUFFERS)-1:0]      out_victim_index,
  output logic                                out_flush_needed
);
  import scvs_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);

  // configuration registers
  logic                  bulk_r;
  logic [CFG_DATA_W-1:0] page_size_r;
  logic [CFG_DATA_W-1:0] train_size_r;

  // output register: keeps results apart from the engine
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [IDX_W-1:0]      out_victim_r;
  logic                  out_flush_r;

  logic                  eng_idle;
  logic                  eng_res_valid;
  logic                  eng_take;
  res_t                  eng_res;
  logic [IDX_W-1:0]      eng_victim;
  req_t                  req;
  logic                  start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bulk_r       <= 1'b0;
      page_size_r  <= POOL_SIZE_RST;
      train_size_r <= POOL_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BULK_FLUSH: bulk_r       <= cfg_wdata[0];
        CFG_PAGE_SIZE:  page_size_r  <= cfg_wdata;
        CFG_TRAIN_SIZE: train_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a new command goes in only when the engine is idle; the output
  // register may still hold the previous result
  assign in_ready = eng_idle;
  assign start    = in_valid && in_ready;
  assign req      = '{command: in_command, pool: in_pool};

  // engine result moves out once the output register is free or draining
  assign eng_take = eng_res_valid && (!out_valid_r || out_ready);

  scvs_engine #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .NUM_POOLS   (NUM_POOLS)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .req               (req),
    .entry_index       (in_entry_index),
    .bulk_flush_enable (bulk_r),
    .page_size         (page_size_r),
    .train_size        (train_size_r),
    .idle              (eng_idle),
    .res_valid         (eng_res_valid),
    .res_take          (eng_take),
    .res               (eng_res),
    .res_victim        (eng_victim)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      out_status_r <= eng_res.status;
      out_victim_r <= eng_victim;
      out_flush_r  <= eng_res.flush;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_victim_index = out_victim_r;
  assign out_flush_needed = out_flush_r;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the second-chance victim selector: directed and random commands.
module tb;
  import scvs_pkg::*;

  localparam int NBUF  = NUM_BUFFERS_DEF;
  localparam int NPOOL = NUM_POOLS_DEF;
  localparam int IDX_W = $clog2(NBUF);

  // commands above CMD_UNFIX are undefined; CMD_TOP is the highest code the field carries
  localparam logic [CMD_W-1:0] CMD_TOP = '1;
  localparam int SWEEP_ROUNDS = 2;

  localparam int HOLD_CYCLES   = 400;            // long receiver hold-off
  localparam int SETTLE_CYCLES = 2 * NBUF + 8;   // longest sweep plus pipeline
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int NPHASE        = 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int MAX_PRINTS    = 200;
  localparam int BULK_PHASE    = 4;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             pool;
    logic [IDX_W-1:0] entry;
  } buf_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    victim;
    logic                flush;
  } buf_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; the inputs are all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command = CMD_ALLOC;
  logic                  in_pool = 1'b0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_W-1:0]      out_victim_index;
  logic                  out_flush_needed;

  second_chance_victim_select_top #(
    .NUM_BUFFERS(NBUF),
    .NUM_POOLS  (NPOOL)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_pool         (in_pool),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_victim_index(out_victim_index),
    .out_flush_needed(out_flush_needed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the entry state, pointers and registers
  // ---------------------------------------------------------------------------
  logic                  ref_m   [NPOOL][NBUF];
  logic                  dirty_m [NPOOL][NBUF];
  logic [FIX_W-1:0]      fix_m   [NPOOL][NBUF];
  logic [IDX_W-1:0]      hand_m  [NPOOL];
  logic                  bulk_m = 1'b0;
  logic [CFG_DATA_W-1:0] page_sz_m = POOL_SIZE_RST;
  logic [CFG_DATA_W-1:0] train_sz_m = POOL_SIZE_RST;

  // size register clamped to 1..NBUF
  function automatic int pool_span(logic p);
    int n;
    n = p ? int'(train_sz_m) : int'(page_sz_m);
    if (n == 0) n = 1;
    if (n > NBUF) n = NBUF;
    return n;
  endfunction

  // applies one command to the shadow state and returns its result
  function automatic buf_result_t run_command(buf_cmd_t c);
    buf_result_t r;
    int          size;
    int          v;
    int          i;
    bit          found;
    r = '0;
    r.status = STATUS_OK;
    size = pool_span(c.pool);
    if (c.command > CMD_UNFIX) begin
      r.status = STATUS_UNSUPP;
      return r;
    end
    if (c.command == CMD_ALLOC) begin
      if (bulk_m) begin
        r.status = STATUS_UNSUPP;
        return r;
      end
      // a pointer left beyond a shrunk pool restarts at zero
      v = int'(hand_m[c.pool]);
      if (v >= size) v = 0;
      found = 1'b0;
      for (i = 0; i < SWEEP_ROUNDS * size && !found; i++) begin
        if (fix_m[c.pool][v] == 0) begin
          if (ref_m[c.pool][v]) ref_m[c.pool][v] = 1'b0;
          else found = 1'b1;
        end
        if (!found) v = (v + 1) % size;
      end
      if (!found) begin
        r.status = STATUS_NO_FREE;
        return r;
      end
      r.victim = IDX_W'(v);
      r.flush  = dirty_m[c.pool][v];
      dirty_m[c.pool][v] = 1'b0;
      ref_m[c.pool][v]   = 1'b0;
      hand_m[c.pool]     = IDX_W'((v + 1) % size);
      return r;
    end
    if (int'(c.entry) >= size) begin
      r.status = STATUS_RANGE;
      return r;
    end
    case (c.command)
      CMD_REF:   ref_m[c.pool][c.entry] = 1'b1;
      CMD_DIRTY: dirty_m[c.pool][c.entry] = 1'b1;
      CMD_FIX:   if (fix_m[c.pool][c.entry] < FIX_MAX)
                   fix_m[c.pool][c.entry] = fix_m[c.pool][c.entry] + 1'b1;
      default:   if (fix_m[c.pool][c.entry] != 0)
                   fix_m[c.pool][c.entry] = fix_m[c.pool][c.entry] - 1'b1;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters and the mismatch report
  // ---------------------------------------------------------------------------
  buf_cmd_t    cmd_queue[$];        // commands waiting for the driver
  buf_result_t awaited_results[$];  // results predicted at acceptance, oldest first
  int          errors = 0;
  int          cycle_count = 0;
  logic        in_fire = 1'b0;      // a command transaction completed at the last rising edge
  bit          cmd_on_bus = 1'b0;   // driver holds a popped command not yet accepted

  task automatic report_mismatch(string what, int got, int want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of commands with random gaps, changes only at falling edges
  // ---------------------------------------------------------------------------
  int       burst_left = 1;
  int       gap_left = 0;
  logic     next_valid;
  buf_cmd_t cur_cmd;

  always @(negedge clk) begin
    // hold an offered transaction until it is taken
    if (rst_n && !(in_valid && !in_fire)) begin
      next_valid = 1'b0;
      if (in_fire) cmd_on_bus = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_queue.size() > 0) begin
        cur_cmd = cmd_queue.pop_front();
        in_command     <= cur_cmd.command;
        in_pool        <= cur_cmd.pool;
        in_entry_index <= cur_cmd.entry;
        next_valid = 1'b1;
        cmd_on_bus = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  int   hold_asks = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  logic rx_ready;

  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rx_ready = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       rx_ready = 1'b1;                            // never stalls
        1:       rx_ready = ($urandom_range(0, 1) == 1);     // coin flip
        2:       rx_ready = ($urandom_range(0, 3) == 0);     // mostly stalled
        default: rx_ready = ($urandom_range(0, 9) != 0);     // rare stalls
      endcase
    end
    out_ready <= rx_ready;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on command acceptance, checks each result transaction
  // ---------------------------------------------------------------------------
  buf_cmd_t    seen_cmd;
  buf_result_t want;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_fire <= rst_n && in_valid && in_ready;
    // results first: a result can never belong to a command taken at the same edge
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no command outstanding, status", out_status, -1);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_victim_index !== want.victim)
          report_mismatch("victim_index", out_victim_index, want.victim);
        if (out_flush_needed !== want.flush)
          report_mismatch("flush_needed", out_flush_needed, want.flush);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      seen_cmd.command = in_command;
      seen_cmd.pool    = in_pool;
      seen_cmd.entry   = in_entry_index;
      awaited_results.push_back(run_command(seen_cmd));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(logic [CMD_W-1:0] c, logic p, int e);
    buf_cmd_t t;
    t.command = c;
    t.pool    = p;
    t.entry   = IDX_W'(e);
    cmd_queue.push_back(t);
  endtask

  // register writes only happen with nothing in flight, so the shadow copy
  // can follow at once
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BULK_FLUSH: bulk_m = data[0];
      CFG_PAGE_SIZE:  page_sz_m = data;
      CFG_TRAIN_SIZE: train_sz_m = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // bulk-flush word with random upper bits; only bit 0 counts
  function automatic logic [CFG_DATA_W-1:0] bulk_word(logic en);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
    w[0] = en;
    return w;
  endfunction

  // sender pauses until every predicted result is back, then lets a sweep's
  // worth of cycles pass
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || cmd_on_bus || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // weighted mix: allocate heavy, indexes mostly inside the pool
  function automatic buf_cmd_t random_command();
    buf_cmd_t c;
    int       pick;
    c.pool = 1'($urandom_range(0, 1));
    pick   = $urandom_range(0, 99);
    if (pick < 34)      c.command = CMD_ALLOC;
    else if (pick < 54) c.command = CMD_REF;
    else if (pick < 66) c.command = CMD_DIRTY;
    else if (pick < 80) c.command = CMD_FIX;
    else if (pick < 95) c.command = CMD_UNFIX;
    else c.command = CMD_W'($urandom_range(int'(CMD_UNFIX) + 1, int'(CMD_TOP)));
    if ($urandom_range(0, 9) != 0)
      c.entry = IDX_W'($urandom_range(0, pool_span(c.pool) - 1));
    else
      c.entry = IDX_W'($urandom_range(0, NBUF - 1));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] page_plan  [NPHASE] = '{7'd64, 7'd1, 7'd0, 7'd127,
                                                 7'd3, 7'd65, 7'd8, 7'd2};
  logic [CFG_DATA_W-1:0] train_plan [NPHASE] = '{7'd1, 7'd64, 7'd2, 7'd0,
                                                 7'd127, 7'd5, 7'd33, 7'd64};

  initial begin : stimulus
    int ph;
    int k;
    for (ph = 0; ph < NPOOL; ph++) begin
      hand_m[ph] = '0;
      for (k = 0; k < NBUF; k++) begin
        ref_m[ph][k]   = 1'b0;
        dirty_m[ph][k] = 1'b0;
        fix_m[ph][k]   = '0;
      end
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset sizes: plain victim, second chance on a referenced
    // entry, dirty victim, extreme indexes, unfix at zero, undefined commands
    push_cmd(CMD_ALLOC, 1'b0, 0);
    push_cmd(CMD_REF,   1'b0, 1);
    push_cmd(CMD_DIRTY, 1'b0, 1);
    push_cmd(CMD_DIRTY, 1'b0, 2);
    push_cmd(CMD_ALLOC, 1'b0, 0);
    push_cmd(CMD_FIX,   1'b1, NBUF - 1);
    push_cmd(CMD_DIRTY, 1'b1, NBUF - 1);
    push_cmd(CMD_UNFIX, 1'b1, 0);
    push_cmd(CMD_UNFIX + 1'b1, 1'b0, 0);
    push_cmd(CMD_TOP,   1'b1, NBUF - 1);
    push_cmd(CMD_ALLOC, 1'b1, 0);
    wait_drained();

    // size zero acts as one, oversize as the full pool; pool 0 pointer is now
    // past the end; index out of range; every entry fixed
    write_reg(CFG_PAGE_SIZE, 7'd0);
    write_reg(CFG_TRAIN_SIZE, 7'd127);
    push_cmd(CMD_REF,   1'b0, 1);
    push_cmd(CMD_FIX,   1'b0, NBUF - 1);
    push_cmd(CMD_FIX,   1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b0, 0);
    push_cmd(CMD_UNFIX, 1'b0, 0);
    push_cmd(CMD_DIRTY, 1'b0, 0);
    push_cmd(CMD_REF,   1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b1, 0);
    wait_drained();

    // bulk flush: allocate is refused, other commands still work
    write_reg(CFG_BULK_FLUSH, bulk_word(1'b1));
    push_cmd(CMD_ALLOC, 1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b1, 0);
    push_cmd(CMD_REF,   1'b1, 5);
    wait_drained();
    write_reg(CFG_BULK_FLUSH, bulk_word(1'b0));

    // random phases, each under its own register setting
    for (ph = 0; ph < NPHASE; ph++) begin
      wait_drained();
      write_reg(CFG_BULK_FLUSH, bulk_word(ph == BULK_PHASE));
      write_reg(CFG_PAGE_SIZE, page_plan[ph]);
      write_reg(CFG_TRAIN_SIZE, train_plan[ph]);
      repeat (PHASE_ITEMS) cmd_queue.push_back(random_command());
      // receiver goes quiet while the sender keeps pushing: backs up the block
      if (ph == 0) hold_asks++;
    end

    // fix count saturation and unfix at zero on a one-entry pool
    wait_drained();
    write_reg(CFG_BULK_FLUSH, bulk_word(1'b0));
    write_reg(CFG_PAGE_SIZE, 7'd1);
    write_reg(CFG_TRAIN_SIZE, 7'd64);
    repeat (int'(FIX_MAX) + 1) push_cmd(CMD_FIX, 1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b0, 0);
    repeat (int'(FIX_MAX) - 1) push_cmd(CMD_UNFIX, 1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b0, 0);
    push_cmd(CMD_UNFIX, 1'b0, 0);
    push_cmd(CMD_UNFIX, 1'b0, 0);
    push_cmd(CMD_ALLOC, 1'b0, 0);
    for (k = 0; k < 16; k++) cmd_queue.push_back(random_command());

    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
